>>> rtl/core/dlfr_pkg.sv
package dlfr_pkg;

    localparam int DATA_WIDTH  = 16;
    localparam int FRAC_BITS   = 12;
    localparam int ROW_FIELD_W = 6;
    localparam int COL_FIELD_W = 10;

    localparam int CFG_INDEX_WIDTH = 2;
    localparam int CFG_DATA_WIDTH  = 11;
    localparam int IN_COUNT_W      = 11;
    localparam int OUT_COUNT_W     = 7;

    localparam logic [1:0] CMD_WEIGHT     = 2'd0;
    localparam logic [1:0] CMD_BIAS       = 2'd1;
    localparam logic [1:0] CMD_ACTIVATION = 2'd2;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_INPUT_COUNT  = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_OUTPUT_COUNT = 2'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_RELU_ENABLE  = 2'd2;

    typedef struct packed {
        logic [1:0]                   command;
        logic [ROW_FIELD_W-1:0]       row;
        logic [COL_FIELD_W-1:0]       col;
        logic signed [DATA_WIDTH-1:0] data;
        logic                         last;
    } in_item_t;

    typedef struct packed {
        logic [ROW_FIELD_W-1:0]       row_index;
        logic signed [DATA_WIDTH-1:0] value;
        logic                         saturated;
        logic                         last_row;
    } out_item_t;

    typedef struct packed {
        logic take_item;
        logic bias_read;
        logic acc_init;
        logic mac_issue;
        logic out_load;
        logic out_last;
    } ctrl_t;

endpackage

>>> rtl/core/dlfr_ctrl.sv
module dlfr_ctrl #(
    parameter int MAX_INPUTS  = 1024,
    parameter int MAX_OUTPUTS = 64
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  dlfr_pkg::in_item_t                    s_item,
    input  logic [dlfr_pkg::IN_COUNT_W-1:0]       input_count,
    input  logic [dlfr_pkg::OUT_COUNT_W-1:0]      output_count,
    input  logic                                  out_free,
    output dlfr_pkg::ctrl_t                       ctrl,
    output logic [((MAX_OUTPUTS > 1) ? $clog2(MAX_OUTPUTS) : 1)-1:0] row_sel,
    output logic [((MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1)-1:0]   col_sel
);

    localparam int RW  = (MAX_OUTPUTS > 1) ? $clog2(MAX_OUTPUTS) : 1;
    localparam int CW  = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;
    localparam int NW0 = $clog2(MAX_INPUTS + 1);
    localparam int NW  = ((NW0 > dlfr_pkg::IN_COUNT_W) ? NW0 : dlfr_pkg::IN_COUNT_W) + 1;
    localparam int OW  = dlfr_pkg::OUT_COUNT_W + 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BIAS,
        ST_INIT,
        ST_ISSUE,
        ST_DRAIN1,
        ST_DRAIN2,
        ST_OUTPUT
    } state_t;

    state_t          state_reg;
    logic [RW-1:0]   row_reg;
    logic [CW-1:0]   col_reg;
    logic [NW-1:0]   n_in;
    logic [OW-1:0]   n_out;
    logic            row_last;
    logic            col_last;
    logic            start;

    always_comb begin
        n_in  = (NW'(input_count) > NW'(MAX_INPUTS)) ? NW'(MAX_INPUTS) : NW'(input_count);
        n_out = (OW'(output_count) > OW'(MAX_OUTPUTS)) ? OW'(MAX_OUTPUTS) : OW'(output_count);
        row_last = (OW'(row_reg) + OW'(1)) == n_out;
        col_last = (NW'(col_reg) + NW'(1)) == n_in;
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign start   = s_valid && s_ready && (s_item.command == dlfr_pkg::CMD_ACTIVATION)
                     && s_item.last && (n_out != '0);

    always_comb begin
        ctrl.take_item = s_valid && s_ready;
        ctrl.bias_read = (state_reg == ST_BIAS);
        ctrl.acc_init  = (state_reg == ST_INIT);
        ctrl.mac_issue = (state_reg == ST_ISSUE);
        ctrl.out_load  = (state_reg == ST_OUTPUT) && out_free;
        ctrl.out_last  = row_last;
    end

    assign row_sel = row_reg;
    assign col_sel = col_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            row_reg   <= '0;
            col_reg   <= '0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (start) begin
                        row_reg   <= '0;
                        state_reg <= ST_BIAS;
                    end
                end
                ST_BIAS: begin
                    col_reg   <= '0;
                    state_reg <= ST_INIT;
                end
                ST_INIT: begin
                    state_reg <= (n_in == '0) ? ST_OUTPUT : ST_ISSUE;
                end
                ST_ISSUE: begin
                    if (col_last) begin
                        state_reg <= ST_DRAIN1;
                    end else begin
                        col_reg <= col_reg + CW'(1);
                    end
                end
                ST_DRAIN1: begin
                    state_reg <= ST_DRAIN2;
                end
                ST_DRAIN2: begin
                    state_reg <= ST_OUTPUT;
                end
                ST_OUTPUT: begin
                    if (out_free) begin
                        if (row_last) begin
                            state_reg <= ST_IDLE;
                        end else begin
                            row_reg   <= row_reg + RW'(1);
                            state_reg <= ST_BIAS;
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

>>> rtl/core/dlfr_dp.sv
module dlfr_dp #(
    parameter int MAX_INPUTS  = 1024,
    parameter int MAX_OUTPUTS = 64
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  dlfr_pkg::in_item_t    s_item,
    input  dlfr_pkg::ctrl_t       ctrl,
    input  logic                  relu_enable,
    input  logic [((MAX_OUTPUTS > 1) ? $clog2(MAX_OUTPUTS) : 1)-1:0] row_sel,
    input  logic [((MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1)-1:0]   col_sel,
    output logic                  out_free,
    output logic                  m_valid,
    input  logic                  m_ready,
    output dlfr_pkg::out_item_t   m_item
);

    localparam int DW   = dlfr_pkg::DATA_WIDTH;
    localparam int FRAC = dlfr_pkg::FRAC_BITS;
    localparam int RW   = (MAX_OUTPUTS > 1) ? $clog2(MAX_OUTPUTS) : 1;
    localparam int CW   = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;
    localparam int RXW  = ((RW > dlfr_pkg::ROW_FIELD_W) ? RW : dlfr_pkg::ROW_FIELD_W) + 1;
    localparam int CXW  = ((CW > dlfr_pkg::COL_FIELD_W) ? CW : dlfr_pkg::COL_FIELD_W) + 1;
    localparam int PW   = 2 * DW;
    localparam int AW   = PW + CW + 2;
    localparam int QW   = AW - FRAC;
    localparam int WDEPTH = MAX_OUTPUTS * (2 ** CW);

    localparam logic signed [QW-1:0] SAT_HI = QW'((2 ** (DW - 1)) - 1);
    localparam logic signed [QW-1:0] SAT_LO = ~SAT_HI;

    logic signed [DW-1:0] wmem [0:WDEPTH-1];
    logic signed [DW-1:0] bmem [0:MAX_OUTPUTS-1];
    logic signed [DW-1:0] xmem [0:MAX_INPUTS-1];

    logic [RXW-1:0]        row_ext;
    logic [CXW-1:0]        col_ext;
    logic                  row_ok;
    logic                  col_ok;
    logic [RW-1:0]         wr_row;
    logic [CW-1:0]         wr_col;

    logic signed [DW-1:0]  w_q_reg;
    logic signed [DW-1:0]  x_q_reg;
    logic signed [DW-1:0]  bias_q_reg;
    logic signed [PW-1:0]  prod_reg;
    logic signed [AW-1:0]  acc_reg;
    logic                  a_v_reg;
    logic                  b_v_reg;

    logic signed [AW-1:0]  acc_relu;
    logic signed [AW-1:0]  acc_rnd;
    logic signed [QW-1:0]  q;
    logic                  sat_hi;
    logic                  sat_lo;
    logic signed [DW-1:0]  clip;

    logic                  m_valid_reg;
    dlfr_pkg::out_item_t   m_item_reg;

    always_comb begin
        row_ext = RXW'(s_item.row);
        col_ext = CXW'(s_item.col);
        row_ok  = row_ext < RXW'(MAX_OUTPUTS);
        col_ok  = col_ext < CXW'(MAX_INPUTS);
        wr_row  = row_ext[RW-1:0];
        wr_col  = col_ext[CW-1:0];
    end

    always_ff @(posedge aclk) begin
        if (ctrl.take_item && (s_item.command == dlfr_pkg::CMD_WEIGHT) && row_ok && col_ok) begin
            wmem[{wr_row, wr_col}] <= s_item.data;
        end
        if (ctrl.mac_issue) begin
            w_q_reg <= wmem[{row_sel, col_sel}];
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.take_item && (s_item.command == dlfr_pkg::CMD_BIAS) && row_ok) begin
            bmem[wr_row] <= s_item.data;
        end
        if (ctrl.bias_read) begin
            bias_q_reg <= bmem[row_sel];
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.take_item && (s_item.command == dlfr_pkg::CMD_ACTIVATION) && col_ok) begin
            xmem[wr_col] <= s_item.data;
        end
        if (ctrl.mac_issue) begin
            x_q_reg <= xmem[col_sel];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_v_reg <= 1'b0;
            b_v_reg <= 1'b0;
        end else begin
            a_v_reg <= ctrl.mac_issue;
            b_v_reg <= a_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= w_q_reg * x_q_reg;
        if (ctrl.acc_init) begin
            acc_reg <= {{(AW - DW - FRAC){bias_q_reg[DW-1]}}, bias_q_reg, {FRAC{1'b0}}};
        end else if (b_v_reg) begin
            acc_reg <= acc_reg + {{(AW - PW){prod_reg[PW-1]}}, prod_reg};
        end
    end

    // ReLU, round half up to Q3.12, clip
    always_comb begin
        acc_relu = (relu_enable && acc_reg[AW-1]) ? '0 : acc_reg;
        acc_rnd  = acc_relu + {{(AW - FRAC){1'b0}}, 1'b1, {(FRAC - 1){1'b0}}};
        q        = acc_rnd[AW-1:FRAC];
        sat_hi   = q > SAT_HI;
        sat_lo   = q < SAT_LO;
        if (sat_hi) begin
            clip = SAT_HI[DW-1:0];
        end else if (sat_lo) begin
            clip = SAT_LO[DW-1:0];
        end else begin
            clip = q[DW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (ctrl.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.out_load) begin
            m_item_reg.row_index <= dlfr_pkg::ROW_FIELD_W'(row_sel);
            m_item_reg.value     <= clip;
            m_item_reg.saturated <= sat_hi || sat_lo;
            m_item_reg.last_row  <= ctrl.out_last;
        end
    end

    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;
    assign m_item   = m_item_reg;

endmodule

>>> rtl/core/dense_layer_forward_relu.sv
// Fully connected layer with optional ReLU in signed Q3.12. Weight, bias and
// activation items with in-range indices are written to on-chip RAMs; the
// activation item marked last starts the compute if n_out is not zero, and the
// input closes until the final row has been handed to the output register.
// One shared multiply-accumulate unit walks each row: bias read, accumulator
// load, one product per input, two pipeline drain states and an output load,
// which waits on a full output register while m_ready is low. With n_in zero
// the products and drain states are skipped. n_in and n_out are the configured
// counts capped at MAX_INPUTS and MAX_OUTPUTS. The RAMs come up with undefined
// contents and every entry that a compute reads must be written first.
module dense_layer_forward_relu #(
    parameter int MAX_INPUTS  = 1024,
    parameter int MAX_OUTPUTS = 64
) (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    input  logic                                      cfg_wr_en,
    input  logic [dlfr_pkg::CFG_INDEX_WIDTH-1:0]      cfg_index,
    input  logic [dlfr_pkg::CFG_DATA_WIDTH-1:0]       cfg_data,
    input  logic                                      s_valid,
    output logic                                      s_ready,
    input  dlfr_pkg::in_item_t                        s_item,
    output logic                                      m_valid,
    input  logic                                      m_ready,
    output dlfr_pkg::out_item_t                       m_item
);

    localparam int RW = (MAX_OUTPUTS > 1) ? $clog2(MAX_OUTPUTS) : 1;
    localparam int CW = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;

    logic [dlfr_pkg::IN_COUNT_W-1:0]  input_count_reg;
    logic [dlfr_pkg::OUT_COUNT_W-1:0] output_count_reg;
    logic                             relu_enable_reg;

    dlfr_pkg::ctrl_t ctrl;
    logic            out_free;
    logic [RW-1:0]   row_sel;
    logic [CW-1:0]   col_sel;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            input_count_reg  <= dlfr_pkg::IN_COUNT_W'(1024);
            output_count_reg <= dlfr_pkg::OUT_COUNT_W'(10);
            relu_enable_reg  <= 1'b1;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                dlfr_pkg::REG_INPUT_COUNT: begin
                    input_count_reg <= cfg_data[dlfr_pkg::IN_COUNT_W-1:0];
                end
                dlfr_pkg::REG_OUTPUT_COUNT: begin
                    output_count_reg <= cfg_data[dlfr_pkg::OUT_COUNT_W-1:0];
                end
                dlfr_pkg::REG_RELU_ENABLE: begin
                    relu_enable_reg <= cfg_data[0];
                end
                default: begin
                end
            endcase
        end
    end

    dlfr_ctrl #(
        .MAX_INPUTS  (MAX_INPUTS),
        .MAX_OUTPUTS (MAX_OUTPUTS)
    ) u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_item       (s_item),
        .input_count  (input_count_reg),
        .output_count (output_count_reg),
        .out_free     (out_free),
        .ctrl         (ctrl),
        .row_sel      (row_sel),
        .col_sel      (col_sel)
    );

    dlfr_dp #(
        .MAX_INPUTS  (MAX_INPUTS),
        .MAX_OUTPUTS (MAX_OUTPUTS)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_item      (s_item),
        .ctrl        (ctrl),
        .relu_enable (relu_enable_reg),
        .row_sel     (row_sel),
        .col_sel     (col_sel),
        .out_free    (out_free),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_item      (m_item)
    );

endmodule

>>> tb/tb_dense_layer_forward_relu.sv
`timescale 1ns / 100ps

module tb_dense_layer_forward_relu;

    localparam int MAX_IN = 1024;
    localparam int MAX_OUT = 64;
    localparam int HOLDOFF_CYCLES = 500;
    localparam logic [1:0] CMD_RESERVED = 2'd3;
    localparam logic [dlfr_pkg::CFG_INDEX_WIDTH-1:0] REG_SPARE = 2'd3;

    logic aclk;
    logic aresetn = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [dlfr_pkg::CFG_INDEX_WIDTH-1:0] cfg_index = '0;
    logic [dlfr_pkg::CFG_DATA_WIDTH-1:0] cfg_data = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    dlfr_pkg::in_item_t s_item = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    dlfr_pkg::out_item_t m_item;

    dense_layer_forward_relu dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_item(s_item),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_item(m_item)
    );

    // layer state mirror
    bit signed [15:0] weight_mem [MAX_OUT][MAX_IN];
    bit signed [15:0] bias_mem [MAX_OUT];
    bit signed [15:0] act_mem [MAX_IN];
    int in_count_cfg = 1024;
    int out_count_cfg = 10;
    bit relu_cfg = 1'b1;

    // entries that queued items will write, marked as each item is queued
    bit weight_seen [MAX_OUT][MAX_IN];
    bit bias_seen [MAX_OUT];
    bit act_seen [MAX_IN];

    dlfr_pkg::in_item_t pending_items[$];
    dlfr_pkg::out_item_t rows_expected[$];
    int items_queued = 0;
    int items_accepted = 0;
    int error_count = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    bit holdoff_go = 1'b0;
    logic recv_blocked = 1'b0;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic int eff_inputs();
        return in_count_cfg > MAX_IN ? MAX_IN : in_count_cfg;
    endfunction

    function automatic int eff_rows();
        return out_count_cfg > MAX_OUT ? MAX_OUT : out_count_cfg;
    endfunction

    function automatic void forward_rows();
        int n_in;
        int n_out;
        longint acc;
        longint v;
        dlfr_pkg::out_item_t res;
        n_in = eff_inputs();
        n_out = eff_rows();
        for (int r = 0; r < n_out; r++) begin
            acc = longint'(bias_mem[r]) * 4096;
            for (int c = 0; c < n_in; c++)
                acc += longint'(weight_mem[r][c]) * longint'(act_mem[c]);
            if (relu_cfg && acc < 0)
                acc = 0;
            v = (acc + 64'sd2048) >>> 12;
            res.saturated = 1'b0;
            if (v > 32767) begin
                v = 32767;
                res.saturated = 1'b1;
            end
            if (v < -32768) begin
                v = -32768;
                res.saturated = 1'b1;
            end
            res.row_index = r[dlfr_pkg::ROW_FIELD_W-1:0];
            res.value = v[15:0];
            res.last_row = (r == n_out - 1);
            rows_expected.push_back(res);
        end
    endfunction

    function automatic void layer_apply(dlfr_pkg::in_item_t it);
        case (it.command)
            dlfr_pkg::CMD_WEIGHT: weight_mem[it.row][it.col] = it.data;
            dlfr_pkg::CMD_BIAS: bias_mem[it.row] = it.data;
            dlfr_pkg::CMD_ACTIVATION: begin
                act_mem[it.col] = it.data;
                if (it.last)
                    forward_rows();
            end
            default: ;
        endcase
    endfunction

    function automatic void check_row(dlfr_pkg::out_item_t got);
        dlfr_pkg::out_item_t want;
        if (rows_expected.size() == 0) begin
            $error("unexpected result row_index %0d value %0d", got.row_index,
                   $signed(got.value));
            error_count++;
            return;
        end
        want = rows_expected.pop_front();
        if (got.row_index !== want.row_index) begin
            $error("row_index: expected %0d, got %0d", want.row_index, got.row_index);
            error_count++;
        end
        if (got.value !== want.value) begin
            $error("value: expected %0d, got %0d", $signed(want.value), $signed(got.value));
            error_count++;
        end
        if (got.saturated !== want.saturated) begin
            $error("saturated: expected %0b, got %0b", want.saturated, got.saturated);
            error_count++;
        end
        if (got.last_row !== want.last_row) begin
            $error("last_row: expected %0b, got %0b", want.last_row, got.last_row);
            error_count++;
        end
    endfunction

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                layer_apply(s_item);
                items_accepted++;
            end
            if (!s_valid || s_ready) begin
                if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_item <= pending_items.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready)
                check_row(m_item);
            m_ready <= !recv_blocked && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // long receiver hold-off
    initial begin
        wait (holdoff_go);
        @(posedge aclk);
        recv_blocked <= 1'b1;
        repeat (HOLDOFF_CYCLES) @(posedge aclk);
        recv_blocked <= 1'b0;
    end

    initial begin
        #20ms;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic void queue_item(logic [1:0] cmd, int row, int col, int data, bit last);
        dlfr_pkg::in_item_t it;
        it.command = cmd;
        it.row = row[dlfr_pkg::ROW_FIELD_W-1:0];
        it.col = col[dlfr_pkg::COL_FIELD_W-1:0];
        it.data = data[15:0];
        it.last = last;
        pending_items.push_back(it);
        items_queued++;
        case (cmd)
            dlfr_pkg::CMD_WEIGHT: weight_seen[it.row][it.col] = 1'b1;
            dlfr_pkg::CMD_BIAS: bias_seen[it.row] = 1'b1;
            dlfr_pkg::CMD_ACTIVATION: act_seen[it.col] = 1'b1;
            default: ;
        endcase
    endfunction

    function automatic int rand_data();
        case ($urandom_range(2))
            0: return int'($urandom_range(65535));
            1: return int'($urandom_range(8192)) - 4096;
            default: return int'($urandom_range(1024)) - 512;
        endcase
    endfunction

    function automatic int pick(int n, int full);
        return n > 0 ? int'($urandom_range(n - 1)) : int'($urandom_range(full - 1));
    endfunction

    function automatic void queue_noise();
        case ($urandom_range(3))
            0: queue_item(CMD_RESERVED, $urandom_range(63), $urandom_range(1023),
                          rand_data(), $urandom_range(1));
            1: queue_item(dlfr_pkg::CMD_WEIGHT, $urandom_range(63), $urandom_range(1023),
                          rand_data(), $urandom_range(1));
            2: queue_item(dlfr_pkg::CMD_BIAS, $urandom_range(63), $urandom_range(1023),
                          rand_data(), $urandom_range(1));
            default: queue_item(dlfr_pkg::CMD_ACTIVATION, $urandom_range(63),
                                $urandom_range(1023), rand_data(), 1'b0);
        endcase
    endfunction

    // one vector: random writes, noise, fill anything the compute reads, then last
    function automatic void queue_vector(int extras, int noise);
        int n_in;
        int n_out;
        int col;
        n_in = eff_inputs();
        n_out = eff_rows();
        for (int i = 0; i < extras; i++) begin
            case ($urandom_range(2))
                0: queue_item(dlfr_pkg::CMD_WEIGHT, pick(n_out, MAX_OUT), pick(n_in, MAX_IN),
                              rand_data(), 1'b0);
                1: queue_item(dlfr_pkg::CMD_BIAS, pick(n_out, MAX_OUT), $urandom_range(1023),
                              rand_data(), 1'b0);
                default: queue_item(dlfr_pkg::CMD_ACTIVATION, $urandom_range(63),
                                    pick(n_in, MAX_IN), rand_data(), 1'b0);
            endcase
        end
        for (int i = 0; i < noise; i++)
            queue_noise();
        for (int r = 0; r < n_out; r++) begin
            if (!bias_seen[r])
                queue_item(dlfr_pkg::CMD_BIAS, r, $urandom_range(1023), rand_data(), 1'b0);
            for (int c = 0; c < n_in; c++)
                if (!weight_seen[r][c])
                    queue_item(dlfr_pkg::CMD_WEIGHT, r, c, rand_data(), 1'b0);
        end
        if (n_out > 0)
            for (int c = 0; c < n_in; c++)
                if (!act_seen[c])
                    queue_item(dlfr_pkg::CMD_ACTIVATION, $urandom_range(63), c, rand_data(),
                               1'b0);
        col = (n_in > 0 && $urandom_range(3) != 0) ? int'($urandom_range(n_in - 1))
                                                   : int'($urandom_range(1023));
        queue_item(dlfr_pkg::CMD_ACTIVATION, $urandom_range(63), col, rand_data(), 1'b1);
    endfunction

    task automatic write_reg(logic [dlfr_pkg::CFG_INDEX_WIDTH-1:0] idx, int val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val[dlfr_pkg::CFG_DATA_WIDTH-1:0];
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            dlfr_pkg::REG_INPUT_COUNT: in_count_cfg = val & 'h7FF;
            dlfr_pkg::REG_OUTPUT_COUNT: out_count_cfg = val & 'h7F;
            dlfr_pkg::REG_RELU_ENABLE: relu_cfg = val[0];
            default: ;
        endcase
    endtask

    task automatic configure(int n_in, int n_out, bit relu);
        write_reg(dlfr_pkg::REG_INPUT_COUNT, n_in);
        write_reg(dlfr_pkg::REG_OUTPUT_COUNT, n_out);
        write_reg(dlfr_pkg::REG_RELU_ENABLE, relu);
    endtask

    // wait for every item and result, then for a further bound scaled by the row and input counts
    task automatic drain();
        while (items_accepted != items_queued || rows_expected.size() != 0)
            @(posedge aclk);
        repeat ((eff_rows() + 1) * (eff_inputs() + 6) + 32) @(posedge aclk);
    endtask

    int send_pct_by_phase[4] = '{0, 45, 0, 11};
    int recv_pct_by_phase[4] = '{0, 0, 45, 11};

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        configure(1, 4, 1'b0);
        write_reg(REG_SPARE, 2047);
        queue_item(dlfr_pkg::CMD_WEIGHT, 0, 0, 1, 1'b0);
        queue_item(dlfr_pkg::CMD_BIAS, 0, 0, 0, 1'b0);
        queue_item(dlfr_pkg::CMD_WEIGHT, 1, 0, 'h7FFF, 1'b0);
        queue_item(dlfr_pkg::CMD_BIAS, 1, 0, 'h7FFF, 1'b0);
        queue_item(dlfr_pkg::CMD_WEIGHT, 2, 0, 'h8000, 1'b0);
        queue_item(dlfr_pkg::CMD_BIAS, 2, 0, 'h8000, 1'b1);
        queue_item(dlfr_pkg::CMD_WEIGHT, 3, 0, -1, 1'b1);
        queue_item(dlfr_pkg::CMD_BIAS, 3, 1023, 0, 1'b0);
        queue_item(dlfr_pkg::CMD_WEIGHT, 63, 1023, 'h5A5A, 1'b0);
        queue_item(CMD_RESERVED, 63, 1023, 'hFFFF, 1'b1);
        queue_item(dlfr_pkg::CMD_ACTIVATION, 0, 0, 2048, 1'b1);
        queue_item(dlfr_pkg::CMD_ACTIVATION, 63, 0, -2048, 1'b1);
        queue_item(dlfr_pkg::CMD_ACTIVATION, 0, 0, 'h7FFF, 1'b0);
        queue_item(dlfr_pkg::CMD_ACTIVATION, 0, 1023, 'h8000, 1'b1);
        drain();
        write_reg(dlfr_pkg::REG_RELU_ENABLE, 1);
        queue_item(dlfr_pkg::CMD_ACTIVATION, 21, 0, -2048, 1'b1);
        drain();

        configure(0, 127, 1'b0);
        queue_vector(0, 0);
        drain();
        configure(1024, 0, 1'b1);
        queue_vector(2, 1);
        drain();
        configure(2047, 0, 1'b0);
        queue_vector(2, 0);
        drain();
        configure(5, 0, 1'b1);
        queue_vector(3, 2);
        drain();
        configure(1, 64, 1'b1);
        queue_vector(2, 0);
        drain();

        // block fills up while the receiver holds off
        configure(4, 8, 1'b0);
        repeat (6) queue_vector($urandom_range(4), 0);
        holdoff_go = 1'b1;
        drain();

        for (int p = 0; p < 4; p++) begin
            send_idle_pct = send_pct_by_phase[p];
            recv_stall_pct = recv_pct_by_phase[p];
            for (int s = 0; s < 2; s++) begin
                configure($urandom_range(7) == 0 ? 0 : $urandom_range(1, 8),
                          $urandom_range(9) == 0 ? 0 :
                          ($urandom_range(9) == 0 ? $urandom_range(9, 16)
                                                  : $urandom_range(1, 6)),
                          $urandom_range(1));
                repeat (3) queue_vector($urandom_range(6), $urandom_range(2));
                drain();
            end
        end

        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/dlfr_pkg.sv
rtl/core/dlfr_ctrl.sv
rtl/core/dlfr_dp.sv
rtl/core/dense_layer_forward_relu.sv
tb/tb_dense_layer_forward_relu.sv
